// ===== rtl/core/urrb_pkg.sv =====
// Shared types and constants for the UART receive ring buffer tracker.
`timescale 1ns / 1ps

package urrb_pkg;

  // Default ring size; the top level hands it down as BUF_SIZE.
  localparam int BUF_SIZE_DEF = 64;

  // Fixed field widths of the stream payloads.
  localparam int BYTE_W  = 8;
  localparam int LIMIT_W = 7;
  localparam int AVAIL_W = 7;
  localparam int FLAG_W  = 3;

  // Fault flag bit positions.
  localparam int FLAG_OVF  = 0;
  localparam int FLAG_XFER = 1;
  localparam int FLAG_LINE = 2;

  // Error kind codes carried with an error event.
  localparam logic ERR_LINE = 1'b0;
  localparam logic ERR_XFER = 1'b1;

  // Command queue between the front and the back.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [2:0] {
    REQ_BYTE   = 3'd0,
    REQ_READ   = 3'd1,
    REQ_ERROR  = 3'd2,
    REQ_FLUSH  = 3'd3,
    REQ_STATUS = 3'd4
  } req_t;

  typedef struct packed {
    req_t                kind;
    logic [BYTE_W-1:0]   rx_byte;
    logic [LIMIT_W-1:0]  read_limit;
    logic                error_kind;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               data_valid;
    logic               last;
    logic [AVAIL_W-1:0] available;
    logic [FLAG_W-1:0]  flags;
  } result_t;

endpackage

// ===== rtl/core/uart_rx_ring_buffer_tracker_core.sv =====
// Top level of the UART receive ring buffer tracker.
`timescale 1ns / 1ps
//
// Requests enter on the in_ stream: in_tuser selects byte arrival, read, error
// event, flush or status query; in_tdata carries the byte, read limit and
// error kind. Results leave on the out_ stream, one transaction per byte read,
// or a single transaction without data for a status query or an empty read;
// out_tlast marks the final result of a request.
// A request passes a two-entry command queue before the back end runs it, so
// with an idle back end the first result of a request appears in the cycle
// after the request leaves the queue.
// Byte arrival, error event and flush are taken without waiting on the receiver.
// A read streams its bytes one after another, paced by the single read port of
// the ring memory; the back end takes no new command until the read is done.
// Reset clears the positions, fill count, fault flags and queue; the ring
// contents are undefined until written.
// When the receiver stalls, the result register holds, the next read or status
// query waits in the back end, and in_tready drops once the command queue is
// full.
module uart_rx_ring_buffer_tracker_core #(
  parameter int BUF_SIZE = urrb_pkg::BUF_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // rx_byte[7:0], read_limit[14:8], error_kind[15]
  input  logic [2:0]  in_tuser,  // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // data_byte[7:0], available[14:8], overflow_flag[15], transfer_fault_flag[16],
  // line_fault_flag[17], zero[23:18]
  output logic [23:0] out_tdata,
  output logic        out_tuser, // data_valid
  output logic        out_tlast
);

  logic              cmd_valid;
  logic              cmd_ready;
  urrb_pkg::cmd_t    cmd;
  urrb_pkg::result_t res;

  urrb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  urrb_back #(
    .BUF_SIZE(BUF_SIZE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res      (res)
  );

  assign out_tdata = {6'd0,
                      res.flags[urrb_pkg::FLAG_LINE],
                      res.flags[urrb_pkg::FLAG_XFER],
                      res.flags[urrb_pkg::FLAG_OVF],
                      res.available,
                      res.data_byte};
  assign out_tuser = res.data_valid;
  assign out_tlast = res.last;

  // A byte is only ever delivered while no fault is set.
  a_data_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[17:15] == 3'd0)
    else $error("data result delivered with a fault flag set");

  // Any fault hides the pending count.
  a_fault_hides_avail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[17:15] != 3'd0) |-> out_tdata[14:8] == 7'd0)
    else $error("available nonzero while a fault flag is set");

  // A result without data is always a lone, final result with a zero byte.
  a_nodata_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata[7:0] == 8'd0)
    else $error("result without data is not last or carries a byte");

endmodule

// ===== rtl/core/urrb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module urrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/urrb_front.sv =====
// Front end: accepts requests, drops unknown codes and queues commands.
`timescale 1ns / 1ps

module urrb_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [15:0]            in_tdata,
  input  logic [2:0]             in_tuser,
  output logic                   cmd_valid,
  input  logic                   cmd_ready,
  output urrb_pkg::cmd_t         cmd
);

  urrb_pkg::cmd_t                 q_r [urrb_pkg::CMDQ_DEPTH];
  logic [urrb_pkg::CMDQ_PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [urrb_pkg::CMDQ_PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [urrb_pkg::CMDQ_CW-1:0]   cnt_r, cnt_nxt;
  logic                           known;
  logic                           push;
  logic                           pop;
  urrb_pkg::cmd_t                 new_cmd;

  always_comb begin
    unique case (in_tuser) inside
      urrb_pkg::REQ_BYTE, urrb_pkg::REQ_READ, urrb_pkg::REQ_ERROR,
      urrb_pkg::REQ_FLUSH, urrb_pkg::REQ_STATUS: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  always_comb begin
    new_cmd.kind       = urrb_pkg::req_t'(in_tuser);
    new_cmd.rx_byte    = in_tdata[7:0];
    new_cmd.read_limit = in_tdata[14:8];
    new_cmd.error_kind = in_tdata[15];
  end

  assign in_tready = (cnt_r != urrb_pkg::CMDQ_CW'(urrb_pkg::CMDQ_DEPTH));
  // Unknown request codes are taken from the bus and discarded here.
  assign push      = in_tvalid && in_tready && known;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/urrb_back.sv =====
// Back end: ring store, positions, fill count, fault flags and result register.
`timescale 1ns / 1ps

module urrb_back #(
  parameter int BUF_SIZE = urrb_pkg::BUF_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  urrb_pkg::cmd_t    cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output urrb_pkg::result_t res
);

  localparam int PTR_W  = $clog2(BUF_SIZE);
  localparam int FILL_W = $clog2(BUF_SIZE + 2);
  localparam int AW     = urrb_pkg::AVAIL_W;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_t;

  state_t                          state_r, state_nxt;
  logic [PTR_W-1:0]                wr_pos_r, wr_pos_nxt;
  logic [PTR_W-1:0]                rd_pos_r, rd_pos_nxt;
  logic [PTR_W-1:0]                rd_addr_r, rd_addr_nxt;
  logic [FILL_W-1:0]               fill_r, fill_nxt;
  logic [urrb_pkg::FLAG_W-1:0]     flags_r, flags_nxt;
  logic [AW-1:0]                   remain_r, remain_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_dv_r, out_dv_nxt;
  logic                            out_last_r, out_last_nxt;
  logic [AW-1:0]                   out_avail_r, out_avail_nxt;
  logic [urrb_pkg::FLAG_W-1:0]     out_flags_r, out_flags_nxt;

  logic                            adv;
  logic                            ram_we;
  logic                            ram_re;
  logic [PTR_W-1:0]                ram_raddr;
  logic [urrb_pkg::BYTE_W-1:0]     ram_q;
  logic [AW-1:0]                   fill_w;
  logic [AW-1:0]                   avail_now;
  logic [AW-1:0]                   room;
  logic [AW-1:0]                   chunk;
  logic [AW-1:0]                   chunk_a;
  logic [AW-1:0]                   rd_end;
  logic                            empty_rd;

  urrb_ram #(
    .WIDTH(urrb_pkg::BYTE_W),
    .DEPTH(BUF_SIZE)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_pos_r),
    .wdata(cmd.rx_byte),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // The result register may be reloaded when it is empty or being taken.
  assign adv       = !out_valid_r || res_ready;
  assign fill_w    = AW'(fill_r);
  assign avail_now = (flags_r != '0) ? '0 : fill_w;
  assign empty_rd  = (flags_r != '0) || (cmd.read_limit == '0) || (fill_r == '0);

  // A chunk never runs past the end of the store.
  always_comb begin
    room    = AW'(BUF_SIZE) - AW'(rd_pos_r);
    chunk_a = (fill_w < cmd.read_limit) ? fill_w : cmd.read_limit;
    chunk   = (chunk_a > room) ? room : chunk_a;
    rd_end  = AW'(rd_pos_r) + chunk;
  end

  always_comb begin
    if (state_r != ST_IDLE) begin
      cmd_ready = 1'b0;
    end else begin
      case (cmd.kind) inside
        urrb_pkg::REQ_READ, urrb_pkg::REQ_STATUS: cmd_ready = adv;
        default:                                  cmd_ready = 1'b1;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wr_pos_nxt    = wr_pos_r;
    rd_pos_nxt    = rd_pos_r;
    rd_addr_nxt   = rd_addr_r;
    fill_nxt      = fill_r;
    flags_nxt     = flags_r;
    remain_nxt    = remain_r;
    out_valid_nxt = out_valid_r && !res_ready;
    out_dv_nxt    = out_dv_r;
    out_last_nxt  = out_last_r;
    out_avail_nxt = out_avail_r;
    out_flags_nxt = out_flags_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = rd_addr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          unique case (cmd.kind)
            urrb_pkg::REQ_BYTE: begin
              ram_we     = 1'b1;
              wr_pos_nxt = (wr_pos_r == PTR_W'(BUF_SIZE - 1)) ? '0 : wr_pos_r + 1'b1;
              if (fill_r >= FILL_W'(BUF_SIZE)) begin
                flags_nxt[urrb_pkg::FLAG_OVF] = 1'b1;
              end
              if (fill_r <= FILL_W'(BUF_SIZE)) begin
                fill_nxt = fill_r + 1'b1;
              end
            end
            urrb_pkg::REQ_ERROR: begin
              if (cmd.error_kind == urrb_pkg::ERR_XFER) begin
                flags_nxt[urrb_pkg::FLAG_XFER] = 1'b1;
              end else begin
                flags_nxt[urrb_pkg::FLAG_LINE] = 1'b1;
              end
            end
            urrb_pkg::REQ_FLUSH: begin
              wr_pos_nxt = '0;
              rd_pos_nxt = '0;
              fill_nxt   = '0;
              flags_nxt  = '0;
            end
            urrb_pkg::REQ_STATUS: begin
              out_valid_nxt = 1'b1;
              out_dv_nxt    = 1'b0;
              out_last_nxt  = 1'b1;
              out_avail_nxt = avail_now;
              out_flags_nxt = flags_r;
            end
            urrb_pkg::REQ_READ: begin
              out_valid_nxt = 1'b1;
              out_flags_nxt = flags_r;
              if (empty_rd) begin
                out_dv_nxt    = 1'b0;
                out_last_nxt  = 1'b1;
                out_avail_nxt = avail_now;
              end else begin
                // Commit the whole chunk now; every result shows the state after it.
                ram_re        = 1'b1;
                ram_raddr     = rd_pos_r;
                rd_addr_nxt   = rd_pos_r + 1'b1;
                remain_nxt    = chunk - 1'b1;
                fill_nxt      = fill_r - FILL_W'(chunk);
                rd_pos_nxt    = (rd_end == AW'(BUF_SIZE)) ? '0 : PTR_W'(rd_end);
                out_dv_nxt    = 1'b1;
                out_last_nxt  = (chunk == AW'(1));
                out_avail_nxt = fill_w - chunk;
                if (chunk != AW'(1)) begin
                  state_nxt = ST_STREAM;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_STREAM: begin
        if (adv) begin
          ram_re        = 1'b1;
          rd_addr_nxt   = rd_addr_r + 1'b1;
          remain_nxt    = remain_r - 1'b1;
          out_valid_nxt = 1'b1;
          out_dv_nxt    = 1'b1;
          out_last_nxt  = (remain_r == AW'(1));
          if (remain_r == AW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    remain_r    <= remain_nxt;
    out_dv_r    <= out_dv_nxt;
    out_last_r  <= out_last_nxt;
    out_avail_r <= out_avail_nxt;
    out_flags_r <= out_flags_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_pos_r    <= '0;
      rd_pos_r    <= '0;
      fill_r      <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_pos_r    <= wr_pos_nxt;
      rd_pos_r    <= rd_pos_nxt;
      fill_r      <= fill_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign res_valid      = out_valid_r;
  assign res.data_byte  = out_dv_r ? ram_q : '0;
  assign res.data_valid = out_dv_r;
  assign res.last       = out_last_r;
  assign res.available  = out_avail_r;
  assign res.flags      = out_flags_r;

endmodule
